FILE: sv/psq_pkg.sv
package psq_pkg;

  // fixed widths of the configuration registers
  localparam int LEVEL_BITS  = 12;
  localparam int PERIOD_BITS = 16;

  localparam int NUM_READINGS = 5;
  // median sits at rank two of five
  localparam int MEDIAN_RANK  = 2;
  localparam int QUEUE_DEPTH  = 4;

  // mode codes as seen on the result
  localparam logic [1:0] MODE_WARMUP   = 2'd0;
  localparam logic [1:0] MODE_SETTLING = 2'd1;
  localparam logic [1:0] MODE_RUNNING  = 2'd2;

  // estimator action codes
  localparam logic [1:0] ACT_HOLD  = 2'd0;
  localparam logic [1:0] ACT_RESET = 2'd1;
  localparam logic [1:0] ACT_FEED  = 2'd2;

  // register indexes on the apb port
  localparam int REG_IDX_BITS = 2;
  localparam logic [REG_IDX_BITS-1:0] REG_NEAR_ZERO  = 2'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_STEP_LIMIT = 2'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_WARMUP     = 2'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_SETTLE     = 2'd3;

  // register reset values (1500 ms at a 10 ms period for both timers)
  localparam logic [LEVEL_BITS-1:0]  NEAR_ZERO_RESET  = LEVEL_BITS'(50);
  localparam logic [LEVEL_BITS-1:0]  STEP_LIMIT_RESET = LEVEL_BITS'(600);
  localparam logic [PERIOD_BITS-1:0] WARMUP_RESET     = PERIOD_BITS'(1500 / 10);
  localparam logic [PERIOD_BITS-1:0] SETTLE_RESET     = PERIOD_BITS'(1500 / 10);

  typedef struct packed {
    logic [LEVEL_BITS-1:0]  near_zero_level;
    logic [LEVEL_BITS-1:0]  step_limit;
    logic [PERIOD_BITS-1:0] warmup_periods;
    logic [PERIOD_BITS-1:0] settle_periods;
  } cfg_t;

  typedef struct packed {
    logic [1:0] action;
    logic       transient_seen;
    logic [1:0] mode_now;
  } result_t;

endpackage

FILE: sv/psq_front.sv
module psq_front #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] readings [psq_pkg::NUM_READINGS],
  input  logic                   queue_full,
  output logic                   push,
  output logic [SAMPLE_BITS-1:0] median
);

  localparam int N = psq_pkg::NUM_READINGS;

  logic                   valid;
  logic [SAMPLE_BITS-1:0] median_comb;
  logic [2:0]             rank [N];

  // rank of each reading, ties broken by position, then pick rank two
  always_comb begin
    median_comb = readings[0];
    for (int i = 0; i < N; i++) begin
      rank[i] = 3'd0;
      for (int j = 0; j < N; j++) begin
        if (j != i) begin
          rank[i] = rank[i] + {2'b00, (readings[j] < readings[i]) ||
                                       ((readings[j] == readings[i]) && (j < i))};
        end
      end
      if (rank[i] == 3'(psq_pkg::MEDIAN_RANK)) begin
        median_comb = readings[i];
      end
    end
  end

  assign push     = valid && !queue_full;
  assign in_ready = !valid || push;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      median <= median_comb;
    end
  end

endmodule

FILE: sv/psq_queue.sv
module psq_queue #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             not_empty,
  output logic             full
);

  // depth is a power of two so the pointers wrap on their own
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CW-1:0]    count;

  assign dout      = entries[rptr];
  assign not_empty = (count != '0);
  assign full      = (count == CW'(DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + PW'(1);
      end
      if (pop) begin
        rptr <= rptr + PW'(1);
      end
      count <= count + CW'(push) - CW'(pop);
    end
    if (push) begin
      entries[wptr] <= din;
    end
  end

endmodule

FILE: sv/psq_back.sv
module psq_back #(
  parameter int SAMPLE_BITS = 12,
  parameter int COUNT_BITS  = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  psq_pkg::cfg_t          cfg,
  input  logic                   q_valid,
  input  logic [SAMPLE_BITS-1:0] q_median,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SAMPLE_BITS-1:0] out_median,
  output psq_pkg::result_t       out_res
);

  localparam int LB = psq_pkg::LEVEL_BITS;
  localparam int PB = psq_pkg::PERIOD_BITS;
  localparam int MW = (SAMPLE_BITS > LB) ? SAMPLE_BITS : LB;
  localparam int WW = (COUNT_BITS > PB) ? COUNT_BITS : PB;
  localparam logic [WW-1:0] COUNT_MAX_W = WW'({COUNT_BITS{1'b1}});

  typedef enum logic [1:0] {
    ST_WARMUP   = psq_pkg::MODE_WARMUP,
    ST_SETTLING = psq_pkg::MODE_SETTLING,
    ST_RUNNING  = psq_pkg::MODE_RUNNING
  } mode_t;

  mode_t                  mode, mode_next;
  logic                   primed;
  logic [SAMPLE_BITS-1:0] prev_median;
  logic [COUNT_BITS-1:0]  periods_left, periods_left_next;
  logic [1:0]             action_next;
  logic                   transient;
  logic [SAMPLE_BITS-1:0] step;
  logic [COUNT_BITS-1:0]  warm_load, settle_load;
  logic                   expires;

  // period register clipped to the counter range
  function automatic logic [COUNT_BITS-1:0] load_count(input logic [PB-1:0] p);
    logic [WW-1:0] pw;
    pw = WW'(p);
    return (pw > COUNT_MAX_W) ? {COUNT_BITS{1'b1}} : COUNT_BITS'(pw);
  endfunction

  assign warm_load   = load_count(cfg.warmup_periods);
  assign settle_load = load_count(cfg.settle_periods);
  assign expires     = (periods_left <= COUNT_BITS'(1));
  assign pop         = q_valid && (!out_valid || out_ready);

  assign step = (q_median >= prev_median) ? (q_median - prev_median)
                                          : (prev_median - q_median);
  assign transient = (MW'(q_median) < MW'(cfg.near_zero_level)) ||
                     (MW'(step) > MW'(cfg.step_limit));

  always_comb begin
    mode_next         = mode;
    periods_left_next = periods_left;
    action_next       = psq_pkg::ACT_HOLD;
    if (!primed) begin
      mode_next         = ST_WARMUP;
      periods_left_next = warm_load;
      action_next       = psq_pkg::ACT_RESET;
    end else begin
      unique case (mode)
        ST_WARMUP: begin
          if (expires) begin
            mode_next         = ST_SETTLING;
            periods_left_next = settle_load;
          end else begin
            periods_left_next = periods_left - COUNT_BITS'(1);
          end
        end
        ST_SETTLING: begin
          if (transient) begin
            periods_left_next = settle_load;
          end else if (expires) begin
            periods_left_next = '0;
            action_next       = psq_pkg::ACT_RESET;
            mode_next         = ST_RUNNING;
          end else begin
            periods_left_next = periods_left - COUNT_BITS'(1);
          end
        end
        default: begin
          if (transient) begin
            mode_next         = ST_SETTLING;
            periods_left_next = settle_load;
          end else begin
            action_next = psq_pkg::ACT_FEED;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= ST_WARMUP;
      primed       <= 1'b0;
      prev_median  <= '0;
      periods_left <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (pop) begin
        mode         <= mode_next;
        primed       <= 1'b1;
        prev_median  <= q_median;
        periods_left <= periods_left_next;
      end
      if (pop) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (pop) begin
      out_median             <= q_median;
      out_res.action         <= action_next;
      out_res.transient_seen <= primed && transient;
      out_res.mode_now       <= mode_next;
    end
  end

endmodule

FILE: sv/pulse_sample_contact_qualifier_unit.sv
// pulse sample contact qualifier
// the input stream carries the five raw converter readings of one sample
// period per transfer; the output stream carries one result per input
// transfer: the median of the five, the estimator action (hold, reset with
// sample, feed sample), a transient flag and the mode after the item
// the front takes a transfer into a register and forms the median with a
// rank network; a four-entry queue parts it from the back, which runs the
// warm-up / settling / running machine and holds the result register
// an input transfer reaches output tvalid through the front register, the
// queue and the result register; throughput: one item per cycle while the
// output is not stalled, set by the single mode update per cycle in the back
// a stalled output fills the queue first, then the front register, and
// only then drops s_tready
// reset (synchronous, active high) empties the pipe, restores all four
// registers to their defaults and puts the machine back in warm-up; the
// first item after reset primes the filter and orders an estimator reset
// registers (apb, byte address): 0x0 near-zero level, 0x4 step limit,
// 0x8 warm-up periods, 0xc settling periods; write only while idle
module pulse_sample_contact_qualifier_unit #(
  parameter int SAMPLE_BITS = 12,
  parameter int COUNT_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  // input stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // reading_one, reading_two, reading_three, reading_four, reading_five
  input  logic [(psq_pkg::NUM_READINGS*SAMPLE_BITS+7)/8*8-1:0] s_tdata,
  // output stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // median_sample, action, transient_seen, mode_now
  output logic [(SAMPLE_BITS+$bits(psq_pkg::result_t)+7)/8*8-1:0] m_tdata,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [3:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int N         = psq_pkg::NUM_READINGS;
  localparam int RES_BITS  = $bits(psq_pkg::result_t);
  localparam int OUT_BITS  = SAMPLE_BITS + RES_BITS;
  localparam int OUT_BYTES = (OUT_BITS + 7) / 8;
  localparam int LB        = psq_pkg::LEVEL_BITS;
  localparam int PB        = psq_pkg::PERIOD_BITS;

  psq_pkg::cfg_t          cfg;
  logic [SAMPLE_BITS-1:0] readings [N];
  logic                   f_push;
  logic [SAMPLE_BITS-1:0] f_median;
  logic                   q_full;
  logic                   q_valid;
  logic [SAMPLE_BITS-1:0] q_median;
  logic                   q_pop;
  logic [SAMPLE_BITS-1:0] out_median;
  psq_pkg::result_t       out_res;
  logic                   cfg_write;
  logic [psq_pkg::REG_IDX_BITS-1:0] reg_idx;

  // unpack the readings, first field in the lowest bits
  always_comb begin
    for (int i = 0; i < N; i++) begin
      readings[i] = s_tdata[i*SAMPLE_BITS +: SAMPLE_BITS];
    end
  end

  // configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_idx   = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.near_zero_level <= psq_pkg::NEAR_ZERO_RESET;
      cfg.step_limit      <= psq_pkg::STEP_LIMIT_RESET;
      cfg.warmup_periods  <= psq_pkg::WARMUP_RESET;
      cfg.settle_periods  <= psq_pkg::SETTLE_RESET;
    end else if (cfg_write) begin
      unique case (reg_idx)
        psq_pkg::REG_NEAR_ZERO:  cfg.near_zero_level <= pwdata[LB-1:0];
        psq_pkg::REG_STEP_LIMIT: cfg.step_limit      <= pwdata[LB-1:0];
        psq_pkg::REG_WARMUP:     cfg.warmup_periods  <= pwdata[PB-1:0];
        psq_pkg::REG_SETTLE:     cfg.settle_periods  <= pwdata[PB-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      psq_pkg::REG_NEAR_ZERO:  prdata = 32'(cfg.near_zero_level);
      psq_pkg::REG_STEP_LIMIT: prdata = 32'(cfg.step_limit);
      psq_pkg::REG_WARMUP:     prdata = 32'(cfg.warmup_periods);
      psq_pkg::REG_SETTLE:     prdata = 32'(cfg.settle_periods);
      default:                 prdata = '0;
    endcase
  end

  // front: take the transfer and form the median
  psq_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .readings  (readings),
    .queue_full(q_full),
    .push      (f_push),
    .median    (f_median)
  );

  // short queue between the two halves
  psq_queue #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(psq_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (f_push),
    .din      (f_median),
    .pop      (q_pop),
    .dout     (q_median),
    .not_empty(q_valid),
    .full     (q_full)
  );

  // back: mode machine and result register
  psq_back #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_median  (q_median),
    .pop       (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_median(out_median),
    .out_res   (out_res)
  );

  assign m_tdata = (OUT_BYTES*8)'({out_res.mode_now, out_res.transient_seen,
                                   out_res.action, out_median});

  // a pop always lands in the result register
  a_pop_shows: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> m_tvalid)
    else $error("popped item did not reach the output");

  // a result only appears after a pop
  a_valid_from_pop: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(q_pop))
    else $error("output valid without a popped item");

  // running is only entered or kept on a quiet item that resets or feeds
  a_running_quiet: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_res.mode_now == psq_pkg::MODE_RUNNING) |->
      (out_res.action != psq_pkg::ACT_HOLD && !out_res.transient_seen))
    else $error("running result with hold action or transient");

endmodule
